[design/aging_lookup_cache_macros.svh]
// Assertion shorthands for the verification-side checker.
`ifndef AGING_LOOKUP_CACHE_MACROS_SVH
`define AGING_LOOKUP_CACHE_MACROS_SVH

// Clocked on clk, quiet while rst_n is low.
`define ALC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked on clk, checked during reset as well.
`define ALC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/alc_pkg.sv]
`default_nettype none

package alc_pkg;

  // Field widths of the stream payloads
  localparam int KEY_W        = 64;
  localparam int KEY_BYTES_W  = 4;
  localparam int IN_TDATA_W   = 72;
  localparam int SLOT_W       = 3;
  localparam int OUT_TDATA_W  = 8;
  localparam int LT_W         = 8;

  // Configuration port
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int EIU_W        = 4;

  localparam logic REG_MAX_LIFETIME   = 1'b0;
  localparam logic REG_ENTRIES_IN_USE = 1'b1;

  localparam logic [LT_W-1:0]  MAX_LIFETIME_RST   = 8'd255;
  localparam logic [EIU_W-1:0] ENTRIES_IN_USE_RST = 4'd8;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_AGE    = 5'b00100,
    ST_FINISH = 5'b01000,
    ST_SPARE  = 5'b10000
  } state_t;

endpackage

`default_nettype wire

[design/aging_lookup_cache.sv]
// A hit on entry j returns once the read pass reaches entry j;
// a miss returns after two passes over the n entries in use: one read pass
// over the entry RAM to match and pick a victim, one read-modify-write pass to age.
// One key at a time: the next key is taken only after the result is in the output register.
// Reset (synchronous, rst_n low): entries read as zero through per-entry valid bits,
// registers return to max_lifetime 255 and entries_in_use 8; no clearing pass.
`default_nettype none

module aging_lookup_cache #(
  parameter int ENTRIES    = 8,
  parameter int ITEM_BYTES = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // Input stream
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [alc_pkg::IN_TDATA_W-1:0]     in_tdata,   // key[63:0], key_bytes[67:64]
  // Result stream
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [alc_pkg::OUT_TDATA_W-1:0]         out_tdata,  // slot[2:0]
  output logic                                    out_tuser,  // hit[0]
  // Configuration port
  input  wire logic                               cfg_psel,
  input  wire logic                               cfg_penable,
  input  wire logic                               cfg_pwrite,
  input  wire logic [alc_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  wire logic [alc_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [alc_pkg::CFG_DATA_W-1:0]          cfg_prdata,
  output logic                                    cfg_pready
);

  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int ENTRY_W = 8 * ITEM_BYTES;
  localparam int LT_W    = alc_pkg::LT_W;
  localparam int RAM_W   = ENTRY_W + LT_W;

  // Configuration registers
  logic [LT_W-1:0]             max_lifetime_r;
  logic [alc_pkg::EIU_W-1:0]   entries_in_use_r;

  // Sequencer
  alc_pkg::state_t             state_r, state_nxt;
  logic [ENTRY_W-1:0]          key_r, key_nxt;
  logic [ITEM_BYTES-1:0]       bmask_r, bmask_nxt;
  logic [CNT_W-1:0]            n_r, n_nxt;
  logic [CNT_W-1:0]            rd_cnt_r, rd_cnt_nxt;
  logic                        chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]            chk_idx_r, chk_idx_nxt;
  logic [IDX_W-1:0]            vic_idx_r, vic_idx_nxt;
  logic [LT_W-1:0]             vic_lt_r, vic_lt_nxt;
  logic                        res_hit_r, res_hit_nxt;
  logic [IDX_W-1:0]            res_idx_r, res_idx_nxt;

  // Output register
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_hit_r, out_hit_nxt;
  logic [alc_pkg::SLOT_W-1:0]  out_slot_r, out_slot_nxt;

  // Entry RAM and valid bits
  logic [ENTRIES-1:0]          valid_r;
  logic                        rd_vld_r;
  logic                        ram_we;
  logic [IDX_W-1:0]            ram_waddr;
  logic [RAM_W-1:0]            ram_wdata;
  logic [IDX_W-1:0]            ram_raddr;
  logic [RAM_W-1:0]            ram_rdata;

  // Datapath helpers
  logic [CNT_W-1:0]            n_eff;
  logic [alc_pkg::KEY_BYTES_W-1:0] nb_in;
  logic [ENTRY_W-1:0]          bit_mask;
  logic [ENTRY_W-1:0]          ent_bytes;
  logic [LT_W-1:0]             ent_lt;
  logic                        match;
  logic                        last_chk;
  logic                        rd_issue;
  logic                        in_xfer;
  logic                        cfg_wr;
  logic                        is_victim;
  logic [LT_W-1:0]             age_lt;

  alc_ram #(
    .WIDTH (RAM_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_xfer    = in_tvalid && in_tready;
  assign in_tready  = (state_r == alc_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(alc_pkg::OUT_TDATA_W - alc_pkg::SLOT_W){1'b0}}, out_slot_r};
  assign out_tuser  = out_hit_r;

  // APB access: always ready, one register per word
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    case (cfg_paddr[2])
      alc_pkg::REG_MAX_LIFETIME:
        cfg_prdata = {{(alc_pkg::CFG_DATA_W - LT_W){1'b0}}, max_lifetime_r};
      alc_pkg::REG_ENTRIES_IN_USE:
        cfg_prdata = {{(alc_pkg::CFG_DATA_W - alc_pkg::EIU_W){1'b0}}, entries_in_use_r};
      default:
        cfg_prdata = '0;
    endcase
  end

  // Entry count clamped to 1..ENTRIES
  always_comb begin
    if (entries_in_use_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(entries_in_use_r) > ENTRIES) begin
      n_eff = CNT_W'(ENTRIES);
    end else begin
      n_eff = CNT_W'(entries_in_use_r);
    end
  end

  // Byte enables of the incoming key, length saturated to ITEM_BYTES
  assign nb_in = in_tdata[alc_pkg::KEY_W +: alc_pkg::KEY_BYTES_W];
  always_comb begin
    for (int b = 0; b < ITEM_BYTES; b++) begin
      bmask_nxt[b] = (b < 32'(nb_in));
    end
    for (int b = 0; b < ITEM_BYTES; b++) begin
      bit_mask[8*b +: 8] = {8{bmask_r[b]}};
    end
  end

  // Entry as read; never-written entries read as zero
  assign ent_bytes = rd_vld_r ? ram_rdata[RAM_W-1:LT_W] : '0;
  assign ent_lt    = rd_vld_r ? ram_rdata[LT_W-1:0]     : '0;
  assign match     = (((ent_bytes ^ key_r) & bit_mask) == '0);
  assign last_chk  = (CNT_W'(chk_idx_r) == (n_r - CNT_W'(1)));
  assign rd_issue  = (rd_cnt_r < n_r);
  assign ram_raddr = rd_issue ? rd_cnt_r[IDX_W-1:0] : '0;
  assign is_victim = (chk_idx_r == vic_idx_r);

  // Aging value: victim restarts at max, then every nonzero lifetime drops by one
  always_comb begin
    logic [LT_W-1:0] lt;
    lt = is_victim ? max_lifetime_r : ent_lt;
    age_lt = (lt != '0) ? (lt - LT_W'(1)) : '0;
  end

  // Sequencer: scan pass, then aging pass on a miss
  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    n_nxt         = n_r;
    rd_cnt_nxt    = rd_cnt_r;
    chk_vld_nxt   = 1'b0;
    chk_idx_nxt   = chk_idx_r;
    vic_idx_nxt   = vic_idx_r;
    vic_lt_nxt    = vic_lt_r;
    res_hit_nxt   = res_hit_r;
    res_idx_nxt   = res_idx_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_hit_nxt   = out_hit_r;
    out_slot_nxt  = out_slot_r;
    ram_we        = 1'b0;
    ram_waddr     = chk_idx_r;
    ram_wdata     = {ent_bytes, max_lifetime_r};

    case (state_r)
      alc_pkg::ST_IDLE: begin
        if (in_xfer) begin
          key_nxt    = in_tdata[ENTRY_W-1:0];
          n_nxt      = n_eff;
          rd_cnt_nxt = '0;
          state_nxt  = alc_pkg::ST_SCAN;
        end
      end

      alc_pkg::ST_SCAN: begin
        if (rd_issue) begin
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = rd_cnt_r[IDX_W-1:0];
          rd_cnt_nxt  = rd_cnt_r + CNT_W'(1);
        end
        if (chk_vld_r) begin
          if (match) begin
            // Hit: refresh lifetime, bytes unchanged
            ram_we      = 1'b1;
            ram_wdata   = {ent_bytes, max_lifetime_r};
            res_hit_nxt = 1'b1;
            res_idx_nxt = chk_idx_r;
            chk_vld_nxt = 1'b0;
            state_nxt   = alc_pkg::ST_FINISH;
          end else begin
            // Earliest smallest lifetime is the victim
            if (chk_idx_r == '0 || ent_lt < vic_lt_r) begin
              vic_idx_nxt = chk_idx_r;
              vic_lt_nxt  = ent_lt;
            end
            if (last_chk) begin
              rd_cnt_nxt  = '0;
              chk_vld_nxt = 1'b0;
              state_nxt   = alc_pkg::ST_AGE;
            end
          end
        end
      end

      alc_pkg::ST_AGE: begin
        if (rd_issue) begin
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = rd_cnt_r[IDX_W-1:0];
          rd_cnt_nxt  = rd_cnt_r + CNT_W'(1);
        end
        if (chk_vld_r) begin
          ram_we = 1'b1;
          if (is_victim) begin
            ram_wdata = {(ent_bytes & ~bit_mask) | (key_r & bit_mask), age_lt};
          end else begin
            ram_wdata = {ent_bytes, age_lt};
          end
          if (last_chk) begin
            res_hit_nxt = 1'b0;
            res_idx_nxt = vic_idx_r;
            chk_vld_nxt = 1'b0;
            state_nxt   = alc_pkg::ST_FINISH;
          end
        end
      end

      alc_pkg::ST_FINISH: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = res_hit_r;
          out_slot_nxt  = alc_pkg::SLOT_W'(res_idx_r);
          state_nxt     = alc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = alc_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= alc_pkg::ST_IDLE;
      chk_vld_r        <= 1'b0;
      out_valid_r      <= 1'b0;
      valid_r          <= '0;
      max_lifetime_r   <= alc_pkg::MAX_LIFETIME_RST;
      entries_in_use_r <= alc_pkg::ENTRIES_IN_USE_RST;
    end else begin
      state_r     <= state_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (ram_we) begin
        valid_r[ram_waddr] <= 1'b1;
      end
      if (cfg_wr) begin
        case (cfg_paddr[2])
          alc_pkg::REG_MAX_LIFETIME:   max_lifetime_r   <= cfg_pwdata[LT_W-1:0];
          alc_pkg::REG_ENTRIES_IN_USE: entries_in_use_r <= cfg_pwdata[alc_pkg::EIU_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    if (in_xfer) begin
      bmask_r  <= bmask_nxt;
    end
    n_r        <= n_nxt;
    rd_cnt_r   <= rd_cnt_nxt;
    chk_idx_r  <= chk_idx_nxt;
    vic_idx_r  <= vic_idx_nxt;
    vic_lt_r   <= vic_lt_nxt;
    res_hit_r  <= res_hit_nxt;
    res_idx_r  <= res_idx_nxt;
    out_hit_r  <= out_hit_nxt;
    out_slot_r <= out_slot_nxt;
    rd_vld_r   <= valid_r[ram_raddr];
  end

endmodule

`default_nettype wire

[design/alc_ram.sv]
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module alc_ram #(
  parameter  int WIDTH  = 72,
  parameter  int DEPTH  = 8,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [ADDR_W-1:0]        waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [ADDR_W-1:0]        raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[design/alc_checker.sv]
`default_nettype none
`include "aging_lookup_cache_macros.svh"

// Port-level checks for the cache
module alc_checker #(
  parameter int ENTRIES = 8
) (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_tvalid,
  input wire logic                               in_tready,
  input wire logic                               out_tvalid,
  input wire logic                               out_tready,
  input wire logic [alc_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input wire logic                               out_tuser,
  input wire logic                               cfg_psel,
  input wire logic                               cfg_penable,
  input wire logic                               cfg_pwrite,
  input wire logic [alc_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input wire logic [alc_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  input wire logic [alc_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  input wire logic                               cfg_pready
);

  logic in_xfer;
  logic wr_lifetime;

  assign in_xfer     = in_tvalid && in_tready;
  assign wr_lifetime = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && (cfg_paddr == '0);

  // A stalled result holds its slot and hit flag
  `ALC_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  // A lookup keeps the block busy: no new key is taken during its scan and finish
  `ALC_ASSERT(a_busy_min, in_xfer |=> !in_tready ##1 !in_tready ##1 !in_tready, "new key taken during a lookup")

  // Reported slot lies inside the cache
  `ALC_ASSERT(a_slot_range, out_tvalid |-> (ENTRIES >= 8) || (32'(out_tdata[2:0]) < ENTRIES), "slot beyond entry count")

  // Lifetime register reads back what was written
  `ALC_ASSERT(a_cfg_readback, wr_lifetime |=> (cfg_paddr != '0) || (cfg_prdata[7:0] == $past(cfg_pwdata[7:0])), "max_lifetime readback mismatch")

  // The configuration port never inserts wait states
  `ALC_ASSERT_ALWAYS(a_pready, cfg_pready, "cfg_pready dropped")

endmodule

bind aging_lookup_cache alc_checker #(.ENTRIES(ENTRIES)) u_alc_checker (.*);

`default_nettype wire

[tb/sv/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_LINES   = 8;
  localparam int LINE_BYTES  = 8;
  localparam int KEY_POOL_SZ = 12;
  localparam int DRAIN_WAIT  = 24;    // longer than the worst miss at 8 lines
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int NUM_PHASES  = 9;
  localparam int PHASE_KEYS  = 148;
  localparam int DIR_ROWS    = 20;

  typedef struct packed {
    logic                       hit;
    logic [alc_pkg::SLOT_W-1:0] slot;
  } lookup_res_t;

  typedef struct packed {
    logic [alc_pkg::KEY_W-1:0]       key;
    logic [alc_pkg::KEY_BYTES_W-1:0] nbytes;
    logic                            pinned;
    lookup_res_t                     res;
  } dir_row_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                               in_tvalid = 1'b0;
  logic                               in_tready;
  logic [alc_pkg::IN_TDATA_W-1:0]     in_tdata  = '0;
  logic                               out_tvalid;
  logic                               out_tready = 1'b0;
  logic [alc_pkg::OUT_TDATA_W-1:0]    out_tdata;
  logic                               out_tuser;
  logic                               cfg_psel    = 1'b0;
  logic                               cfg_penable = 1'b0;
  logic                               cfg_pwrite  = 1'b0;
  logic [alc_pkg::CFG_ADDR_W-1:0]     cfg_paddr   = '0;
  logic [alc_pkg::CFG_DATA_W-1:0]     cfg_pwdata  = '0;
  logic [alc_pkg::CFG_DATA_W-1:0]     cfg_prdata;
  logic                               cfg_pready;

  aging_lookup_cache u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Shadow copy of the cache contents and registers
  logic [alc_pkg::KEY_W-1:0]  line_key [NUM_LINES];
  logic [alc_pkg::LT_W-1:0]   line_age [NUM_LINES];
  logic [alc_pkg::LT_W-1:0]   cur_max_life = alc_pkg::MAX_LIFETIME_RST;
  logic [alc_pkg::EIU_W-1:0]  cur_lines    = alc_pkg::ENTRIES_IN_USE_RST;

  lookup_res_t                pending_res [$];
  lookup_res_t                got_res;
  logic [alc_pkg::KEY_W-1:0]  key_pool [KEY_POOL_SZ];

  int  n_sent     = 0;
  int  n_checked  = 0;
  int  n_errors   = 0;
  int  stall_cnt  = 0;
  bit  idle_on    = 1'b1;
  bit  hold_req   = 1'b0;

  dir_row_t dir_tab [DIR_ROWS] = '{
    // fresh cache: all-zero key hits the empty first line
    '{64'h0,                   4'd8,  1'b1, '{1'b1, 3'd0}},
    '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8,  1'b1, '{1'b0, 3'd1}},
    '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8,  1'b1, '{1'b1, 3'd1}},
    // zero length always matches the first line
    '{64'h0,                   4'd0,  1'b1, '{1'b1, 3'd0}},
    '{64'h12,                  4'd1,  1'b1, '{1'b0, 3'd2}},
    // length above eight saturates
    '{64'hFFFF_FFFF_FFFF_FF12, 4'd15, 1'b0, '0},
    '{64'h3412,                4'd2,  1'b0, '0},
    '{64'h12,                  4'd1,  1'b0, '0},
    '{64'h8000_0000_0000_0000, 4'd8,  1'b0, '0},
    '{64'h1,                   4'd8,  1'b0, '0},
    '{64'h5555_5555_5555_5555, 4'd8,  1'b0, '0},
    '{64'hAAAA_AAAA_AAAA_AAAA, 4'd8,  1'b0, '0},
    '{64'hFEDC_BA98_7654_3210, 4'd4,  1'b0, '0},
    '{64'h0123_4567_89AB_CDEF, 4'd8,  1'b0, '0},
    '{64'hFF,                  4'd3,  1'b0, '0},
    '{64'hDEAD_BEEF_0000_0001, 4'd9,  1'b0, '0},
    '{64'h0123_4567_89AB_CDEF, 4'd8,  1'b0, '0},
    '{64'h5555_5555_5555_5555, 4'd7,  1'b0, '0},
    '{64'h0,                   4'd15, 1'b0, '0},
    '{64'h7FFF_FFFF_FFFF_FFFF, 4'd8,  1'b0, '0}
  };

  // Register settings per random phase; the first keeps the reset values
  int phase_life  [NUM_PHASES] = '{255, 1, 0, 7, 255, 2, 0, 100, 40};
  int phase_lines [NUM_PHASES] = '{8,   1, 0, 4, 15,  8, 8, 3,   8};

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Lookup, replacement and aging on the shadow cache
  task automatic cache_lookup(input logic [alc_pkg::KEY_W-1:0] k,
                              input logic [alc_pkg::KEY_BYTES_W-1:0] nb,
                              output lookup_res_t r);
    int                        n;
    int                        nbs;
    int                        victim;
    bit                        found;
    bit                        done;
    logic [alc_pkg::KEY_W-1:0] m;
    n      = (cur_lines == 0) ? 1 : ((cur_lines > NUM_LINES) ? NUM_LINES : int'(cur_lines));
    nbs    = (nb > LINE_BYTES) ? LINE_BYTES : int'(nb);
    m      = (nbs == 8) ? '1 : ((64'd1 << (8 * nbs)) - 64'd1);
    found  = 1'b0;
    victim = 0;
    r      = '0;
    for (int i = 0; i < n; i++) begin
      if (!found && (((line_key[i] ^ k) & m) == '0)) begin
        found       = 1'b1;
        line_age[i] = cur_max_life;
        r.hit       = 1'b1;
        r.slot      = 3'(i);
      end
    end
    if (!found) begin
      done = 1'b0;
      if (line_age[0] != 0) begin
        for (int i = 1; i < n; i++) begin
          if (!done) begin
            if (line_age[i] == 0) begin
              victim = i;
              done   = 1'b1;
            end else if (line_age[i] < line_age[victim]) begin
              victim = i;
            end
          end
        end
      end
      line_key[victim] = (line_key[victim] & ~m) | (k & m);
      line_age[victim] = cur_max_life;
      for (int i = 0; i < n; i++) begin
        if (line_age[i] != 0) line_age[i] = line_age[i] - 8'd1;
      end
      r.hit  = 1'b0;
      r.slot = 3'(victim);
    end
  endtask

  // One key transaction; valid stays high after acceptance for back-to-back keys
  task automatic send_key(input logic [alc_pkg::KEY_W-1:0] k,
                          input logic [alc_pkg::KEY_BYTES_W-1:0] nb,
                          input bit pinned, input lookup_res_t pinned_res);
    lookup_res_t r;
    while (idle_on && $urandom_range(99) < 24) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= {4'b0, nb, k};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    cache_lookup(k, nb, r);
    pending_res.push_back(pinned ? pinned_res : r);
    n_sent++;
  endtask

  // Register write: setup, access, then idle
  task automatic reg_write(input logic idx, input logic [alc_pkg::CFG_DATA_W-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == alc_pkg::REG_MAX_LIFETIME) cur_max_life = val[alc_pkg::LT_W-1:0];
    else                                  cur_lines    = val[alc_pkg::EIU_W-1:0];
    @(posedge clk);
  endtask

  // Wait until every lookup has returned, then let the block settle
  task automatic drain();
    in_tvalid <= 1'b0;
    wait (n_checked == n_sent);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Mostly keys seen before (hits, partial matches), some near-zero, some fresh
  task automatic pick_key(output logic [alc_pkg::KEY_W-1:0] k,
                          output logic [alc_pkg::KEY_BYTES_W-1:0] nb);
    int sel;
    sel = $urandom_range(99);
    if (sel < 55) begin
      k = key_pool[$urandom_range(KEY_POOL_SZ - 1)];
      if ($urandom_range(1)) k[63:32] = $urandom;
    end else if (sel < 70) begin
      k = {56'h0, 8'($urandom_range(3))};
    end else begin
      k = {$urandom, $urandom};
      key_pool[$urandom_range(KEY_POOL_SZ - 1)] = k;
    end
    sel = $urandom_range(99);
    if (sel < 10)      nb = 4'd0;
    else if (sel < 20) nb = 4'($urandom_range(15, 9));
    else if (sel < 50) nb = 4'd8;
    else               nb = 4'($urandom_range(8, 1));
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_tready <= !(idle_on && $urandom_range(99) < 24);
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_res.size() == 0) begin
        $error("result transaction with nothing pending: hit=%0b slot=%0d",
               out_tuser, out_tdata[alc_pkg::SLOT_W-1:0]);
        n_errors++;
      end else begin
        got_res = pending_res.pop_front();
        if (out_tuser !== got_res.hit) begin
          $error("hit: expected %0b, got %0b", got_res.hit, out_tuser);
          n_errors++;
        end
        if (out_tdata[alc_pkg::SLOT_W-1:0] !== got_res.slot) begin
          $error("slot: expected %0d, got %0d", got_res.slot,
                 out_tdata[alc_pkg::SLOT_W-1:0]);
          n_errors++;
        end
      end
      n_checked++;
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // Main sequence
  initial begin
    logic [alc_pkg::KEY_W-1:0]       k;
    logic [alc_pkg::KEY_BYTES_W-1:0] nb;
    for (int i = 0; i < NUM_LINES; i++) begin
      line_key[i] = '0;
      line_age[i] = '0;
    end
    for (int i = 0; i < KEY_POOL_SZ; i++) key_pool[i] = {$urandom, $urandom};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed keys at reset settings
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_key(dir_tab[i].key, dir_tab[i].nbytes, dir_tab[i].pinned, dir_tab[i].res);
    end
    drain();

    // random phases under different register settings
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p != 0) begin
        reg_write(alc_pkg::REG_MAX_LIFETIME, alc_pkg::CFG_DATA_W'(phase_life[p]));
        reg_write(alc_pkg::REG_ENTRIES_IN_USE, alc_pkg::CFG_DATA_W'(phase_lines[p]));
      end
      idle_on = (p != 5);
      if (p == 3) hold_req = 1'b1;
      for (int j = 0; j < PHASE_KEYS; j++) begin
        pick_key(k, nb);
        send_key(k, nb, 1'b0, '0);
      end
      drain();
    end

    if (pending_res.size() != 0) begin
      $error("%0d lookups never returned a result", pending_res.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
